/* hw/rtl/bbs_pkg.sv */
package bbs_pkg;

   localparam int NUM_BLOCKS   = 256;
   localparam int BLOCK_BYTES  = 512;
   localparam int DIRECT_SLOTS = 8;

   localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int OFF_W  = $clog2(BLOCK_BYTES);
   localparam int ADDR_W = BLK_W + OFF_W;
   localparam int RAM_DEPTH = NUM_BLOCKS * BLOCK_BYTES;

   localparam int GRP    = 16;
   localparam int GRP_W  = 4;
   localparam int NG     = (NUM_BLOCKS + GRP - 1) / GRP;
   localparam int GW     = (NG > 1) ? $clog2(NG) : 1;

   localparam int CNT_W  = 13;
   localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
   localparam logic [31:0]      HASH_SEED = 32'd5381;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_FREE  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FREE   = 2'd1;
   localparam logic [1:0] ST_TOO_LARGE = 2'd2;

   typedef struct packed {
      logic accept;
      logic grp_step;
      logic bit_step;
      logic read_done;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic need_alloc;
      logic is_read;
   } sts_type;

   function automatic logic [BLK_W-1:0] ext_blk(input logic [7:0] v);
      logic [BLK_W+7:0] w;
      w = {{BLK_W{1'b0}}, v};
      return w[BLK_W-1:0];
   endfunction

   function automatic logic [OFF_W-1:0] ext_off(input logic [8:0] v);
      logic [OFF_W+8:0] w;
      w = {{OFF_W{1'b0}}, v};
      return w[OFF_W-1:0];
   endfunction

endpackage

/* hw/rtl/bbs_ram.sv */
module bbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bbs_ctrl.sv */
module bbs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  bbs_pkg::sts_type sts,
   output bbs_pkg::cmd_type cmd
);
   import bbs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GRP,
      S_BIT,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.accept = 1'b1;
               if (sts.need_alloc) begin
                  state_in = S_GRP;
               end else if (sts.is_read) begin
                  state_in = S_READ;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_GRP: begin
            cmd.grp_step = 1'b1;
            state_in     = S_BIT;
         end
         S_BIT: begin
            cmd.bit_step = 1'b1;
            cmd.load     = 1'b1;
            state_in     = S_IDLE;
         end
         S_READ: begin
            cmd.read_done = 1'b1;
            cmd.load      = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* hw/rtl/bbs_datapath.sv */
module bbs_datapath (
   input  logic             clock,
   input  logic             reset,
   input  bbs_pkg::cmd_type cmd,
   output bbs_pkg::sts_type sts,
   input  logic [31:0]      req_tdata,
   input  logic [2:0]       req_tuser,
   output logic [63:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser
);
   import bbs_pkg::*;

   logic [NUM_BLOCKS-1:0] free_ff, free_in;
   logic [BLK_W-1:0]      cur_ff, cur_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [31:0]           hash_ff, hash_in;
   logic [1:0]            err_ff, err_in;
   logic [7:0]            data_pend_ff, data_pend_in;
   logic [2:0]            slot_pend_ff, slot_pend_in;
   logic [GW-1:0]         grp_ff, grp_in;
   logic                  any_ff, any_in;
   logic                  rng_ff, rng_in;
   logic [63:0]           out_data_ff, out_data_in;
   logic [2:0]            out_user_ff, out_user_in;

   logic [1:0]        func;
   logic              first;
   logic [7:0]        data;
   logic [7:0]        bidx;
   logic [8:0]        boff;
   logic [CNT_W-1:0]  c_base, count_next, slot_full;
   logic [1:0]        e_base, e1, e2;
   logic [31:0]       h_base, hash_next;
   logic              need;
   logic              blk_ok, off_ok;

   logic [NG*GRP-1:0] pad;
   logic [NG-1:0]     grp_any;
   logic [GW-1:0]     grp_pick;
   logic [GRP-1:0]    sel_bits;
   logic [GRP_W-1:0]  bit_pick;
   logic [GW+GRP_W-1:0] cat;
   logic [BLK_W-1:0]  found;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   logic [1:0]        o_status;
   logic              o_valid;
   logic [7:0]        o_block, o_read;
   logic [2:0]        o_slot;
   logic [12:0]       o_size;
   logic [31:0]       o_hash;

   assign func  = req_tuser[1:0];
   assign first = req_tuser[2];
   assign data  = req_tdata[7:0];
   assign bidx  = req_tdata[15:8];
   assign boff  = req_tdata[24:16];

   // write bookkeeping for the item at the input
   always_comb begin
      c_base     = first ? '0 : count_ff;
      e_base     = first ? ST_OK : err_ff;
      h_base     = first ? HASH_SEED : hash_ff;
      e1         = (e_base == ST_OK && c_base == COUNT_MAX) ? ST_TOO_LARGE : e_base;
      slot_full  = c_base >> OFF_W;
      need       = 1'b0;
      e2         = e1;
      if (e1 == ST_OK && c_base[OFF_W-1:0] == '0) begin
         if (32'(slot_full) >= DIRECT_SLOTS) begin
            e2 = ST_TOO_LARGE;
         end else begin
            need = 1'b1;
         end
      end
      hash_next  = (h_base << 5) + h_base + 32'(data);
      count_next = (c_base == COUNT_MAX) ? c_base : c_base + 13'd1;
      blk_ok     = 32'(bidx) < NUM_BLOCKS;
      off_ok     = 32'(boff) < BLOCK_BYTES;
   end

   assign sts.need_alloc = (func == FUNC_WRITE) && need;
   assign sts.is_read    = (func == FUNC_READ);

   // two-level first-fit search: group flags, then bits of the chosen group
   always_comb begin
      pad = '0;
      pad[NUM_BLOCKS-1:0] = free_ff;
      for (int g = 0; g < NG; g++) begin
         grp_any[g] = |pad[g*GRP +: GRP];
      end
      grp_pick = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_pick = GW'(g);
         end
      end
      sel_bits = pad[32'(grp_ff)*GRP +: GRP];
      bit_pick = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
         if (sel_bits[b]) begin
            bit_pick = GRP_W'(b);
         end
      end
      cat   = {grp_ff, bit_pick};
      found = cat[BLK_W-1:0];
   end

   always_comb begin
      free_in      = free_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      hash_in      = hash_ff;
      err_in       = err_ff;
      data_pend_in = data_pend_ff;
      slot_pend_in = slot_pend_ff;
      grp_in       = grp_ff;
      any_in       = any_ff;
      rng_in       = rng_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = data;
      rd_en        = 1'b0;
      rd_addr      = {ext_blk(bidx), ext_off(boff)};
      o_status     = ST_OK;
      o_valid      = 1'b0;
      o_block      = '0;
      o_slot       = '0;
      o_read       = '0;
      o_size       = '0;
      o_hash       = '0;

      if (cmd.accept) begin
         case (func)
            FUNC_WRITE: begin
               count_in     = count_next;
               hash_in      = hash_next;
               err_in       = e2;
               data_pend_in = data;
               slot_pend_in = 3'(slot_full);
               if (!need && e2 == ST_OK) begin
                  wr_en   = 1'b1;
                  wr_addr = {cur_ff, c_base[OFF_W-1:0]};
               end
               o_status = e2;
               o_size   = count_next;
               o_hash   = hash_next;
            end
            FUNC_READ: begin
               rd_en  = 1'b1;
               rng_in = blk_ok && off_ok;
            end
            FUNC_FREE: begin
               if (blk_ok) begin
                  free_in[ext_blk(bidx)] = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (cmd.grp_step) begin
         grp_in = grp_pick;
         any_in = |grp_any;
      end

      if (cmd.bit_step) begin
         o_size = count_ff;
         o_hash = hash_ff;
         if (any_ff) begin
            free_in[found] = 1'b0;
            cur_in         = found;
            wr_en          = 1'b1;
            wr_addr        = {found, {OFF_W{1'b0}}};
            wr_data        = data_pend_ff;
            o_valid        = 1'b1;
            o_block        = 8'(found);
            o_slot         = slot_pend_ff;
         end else begin
            err_in   = ST_NO_FREE;
            o_status = ST_NO_FREE;
         end
      end

      if (cmd.read_done) begin
         o_read = rng_ff ? rd_data : 8'd0;
      end

      out_data_in = {o_hash, o_size, o_read, o_slot, o_block};
      out_user_in = {o_valid, o_status};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '1;
         cur_ff   <= '0;
         count_ff <= '0;
         hash_ff  <= HASH_SEED;
         err_ff   <= ST_OK;
      end else begin
         free_ff  <= free_in;
         cur_ff   <= cur_in;
         count_ff <= count_in;
         hash_ff  <= hash_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      data_pend_ff <= data_pend_in;
      slot_pend_ff <= slot_pend_in;
      grp_ff       <= grp_in;
      any_ff       <= any_in;
      rng_ff       <= rng_in;
      if (cmd.load) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   bbs_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

endmodule

/* hw/rtl/bitmap_block_store_with_hash_top.sv */
// block store with a first-fit free map and a running djb2 hash over file bytes
// req channel: one item per command; tuser selects write byte, read byte or free
// block and flags the first byte of a file, tlast marks the last byte of a file
// rsp channel: exactly one item per request, in request order
// a write byte that needs no new block, a free and an unused code load their
// report in the accept state; a read loads it in S_READ (registered block
// memory read port); a write byte that needs a new block goes on to S_GRP,
// which picks the lowest group holding a free block, then to S_BIT, which picks
// the lowest bit in it, stores the byte and loads the report, or reports no free
// block; the next request is taken in the cycle after a result is loaded, while
// the receiver keeps up
// a new request is taken while the previous result waits, as long as the result
// register is empty or drains in that cycle; a stalled receiver holds the
// result and blocks further requests
// reset marks every block free, clears byte count and error, seeds the hash;
// block memory is not cleared, bytes never written read back undefined
module bitmap_block_store_with_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // data_byte[7:0], block_num[15:8], byte_offset[24:16]
   input  logic [2:0]  req_tuser,  // func[1:0], first[2]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // alloc_block[7:0], alloc_slot[10:8], read_byte[18:11],
                                   // file_size[31:19], file_hash[63:32]
   output logic [2:0]  rsp_tuser   // status[1:0], alloc_valid[2]
);
   import bbs_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    unused_last;

   assign unused_last = req_tlast;

   bbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bbs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
